// ===== src/nlej_pkg.sv =====
// Shared types and constants for the nested-loop equi-join block.
// No dependencies; used by every other file in src.
package nlej_pkg;

  localparam int unsigned KEY_W       = 32;
  localparam int unsigned BASE_W      = 32;
  localparam int unsigned POS_W       = 33;
  localparam int unsigned ROWS_W      = 32;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned INNER_DEPTH = 64;

  // item modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_PROBE = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_BASE = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL
  } state_e;

  // probe token walking down the cell row
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } tok_t;

endpackage

// ===== src/nested_loop_equi_join.sv =====
// Nested-loop equi-join: a row of INNER_DEPTH cells holds the inner values; a probe
// token steps one cell per cycle while the scan is not held for the output slot.
// Loads and clears leave the input free. A probe stalls the input while its token walks
// the filled cells (SCAN, skipped on an empty store) and until its last word is sent (FINAL).
// Reset (rst_ni low, async) empties the store, zeroes the row counter and bases;
// stored values are left as they were and are never read before written.
module nested_loop_equi_join #(
  parameter int unsigned INNER_DEPTH = nlej_pkg::INNER_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // item channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           mode_i,
  input  logic signed [nlej_pkg::KEY_W-1:0]    key_value_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [nlej_pkg::POS_W-1:0]           outer_position_o,
  output logic [nlej_pkg::POS_W-1:0]           inner_position_o,
  output logic                                 matched_o,
  output logic                                 last_o,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [nlej_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [nlej_pkg::BASE_W-1:0]          cfg_data_i
);

  localparam int unsigned FILL_W = $clog2(INNER_DEPTH + 1);
  localparam int unsigned IDX_W  = (INNER_DEPTH > 1) ? $clog2(INNER_DEPTH) : 1;

  nlej_pkg::state_e state_q, state_d;

  logic [nlej_pkg::BASE_W-1:0] obase_q, ibase_q;
  logic [FILL_W-1:0]           fill_q;
  logic [nlej_pkg::ROWS_W-1:0] rows_q;
  logic [IDX_W-1:0]            idx_q, last_idx_q;
  logic                        pend_v_q;
  logic [IDX_W-1:0]            pend_idx_q;

  logic                        out_v_q;
  logic [nlej_pkg::POS_W-1:0]  out_opos_q, out_ipos_q;
  logic                        out_m_q, out_l_q;

  // handshakes and control terms
  logic in_acc, out_free, start, do_load, do_clear, hit_any, scan_adv, final_go;
  logic emit;
  logic [nlej_pkg::POS_W-1:0] emit_ipos;
  logic emit_m, emit_l;
  logic [nlej_pkg::POS_W-1:0] opos;

  // cell row wiring
  nlej_pkg::tok_t           tok_in  [INNER_DEPTH];
  nlej_pkg::tok_t           tok_out [INNER_DEPTH];
  logic [INNER_DEPTH-1:0]   hits;

  assign in_stall_o  = (state_q != nlej_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_v_q || !out_stall_i;

  assign start    = in_acc && (mode_i == nlej_pkg::MODE_PROBE);
  assign do_load  = in_acc && (mode_i == nlej_pkg::MODE_LOAD)
                    && (fill_q < FILL_W'(INNER_DEPTH));
  assign do_clear = in_acc && (mode_i == nlej_pkg::MODE_CLEAR);

  assign hit_any = |hits;
  // hold the row when a second match needs the output slot and it is taken
  assign scan_adv = (state_q == nlej_pkg::ST_SCAN) && !(hit_any && pend_v_q && !out_free);
  assign final_go = (state_q == nlej_pkg::ST_FINAL) && out_free;

  assign opos = {1'b0, rows_q} + {1'b0, obase_q};

  // the cell row: cell 0 takes the new token, the rest shift from the left
  for (genvar i = 0; i < INNER_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tok_in[i] = '{valid: start, key: key_value_i};
    end else begin : g_body
      assign tok_in[i] = tok_out[i-1];
    end

    nlej_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_en_i  (do_load && (fill_q == FILL_W'(i))),
      .wr_key_i (key_value_i),
      .shift_i  ((i == 0) ? (start || scan_adv) : scan_adv),
      .flush_i  ((i == 0) ? 1'b0 : start),
      .tok_i    (tok_in[i]),
      .tok_o    (tok_out[i]),
      .hit_o    (hits[i])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nlej_pkg::ST_IDLE: begin
        if (start) begin
          state_d = (fill_q == '0) ? nlej_pkg::ST_FINAL : nlej_pkg::ST_SCAN;
        end
      end
      nlej_pkg::ST_SCAN: begin
        if (scan_adv && (idx_q == last_idx_q)) begin
          state_d = nlej_pkg::ST_FINAL;
        end
      end
      nlej_pkg::ST_FINAL: begin
        if (out_free) begin
          state_d = nlej_pkg::ST_IDLE;
        end
      end
      default: state_d = nlej_pkg::ST_IDLE;
    endcase
  end

  // result selection: a held match goes out once the next one shows up,
  // the final word of a probe goes out from FINAL
  always_comb begin
    emit      = 1'b0;
    emit_ipos = {1'b0, ibase_q} + {{(nlej_pkg::POS_W-IDX_W){1'b0}}, pend_idx_q};
    emit_m    = 1'b1;
    emit_l    = 1'b0;
    unique case (state_q)
      nlej_pkg::ST_SCAN: begin
        emit = scan_adv && hit_any && pend_v_q;
      end
      nlej_pkg::ST_FINAL: begin
        emit   = out_free;
        emit_l = 1'b1;
        if (!pend_v_q) begin
          emit_ipos = '0;
          emit_m    = 1'b0;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= nlej_pkg::ST_IDLE;
      obase_q    <= '0;
      ibase_q    <= '0;
      fill_q     <= '0;
      rows_q     <= '0;
      idx_q      <= '0;
      last_idx_q <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          nlej_pkg::REG_OUTER_BASE: obase_q <= cfg_data_i;
          nlej_pkg::REG_INNER_BASE: ibase_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (do_load) begin
        fill_q <= fill_q + 1'b1;
      end

      if (do_clear) begin
        fill_q <= '0;
        rows_q <= '0;
      end else if (final_go) begin
        rows_q <= rows_q + 1'b1;
      end

      if (start) begin
        idx_q      <= '0;
        last_idx_q <= IDX_W'(fill_q - 1'b1);
        pend_v_q   <= 1'b0;
      end else if (scan_adv) begin
        idx_q <= idx_q + 1'b1;
        if (hit_any) begin
          pend_v_q <= 1'b1;
        end
      end

      if (emit) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (scan_adv && hit_any) begin
      pend_idx_q <= idx_q;
    end
    if (emit) begin
      out_opos_q <= opos;
      out_ipos_q <= emit_ipos;
      out_m_q    <= emit_m;
      out_l_q    <= emit_l;
    end
  end

  assign out_valid_o      = out_v_q;
  assign outer_position_o = out_opos_q;
  assign inner_position_o = out_ipos_q;
  assign matched_o        = out_m_q;
  assign last_o           = out_l_q;

endmodule

// ===== src/nlej_cell.sv =====
// One cell of the inner row: holds a stored inner value and a probe token slot.
// Depends on nlej_pkg.
module nlej_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [nlej_pkg::KEY_W-1:0] wr_key_i,
  input  logic                    shift_i,
  input  logic                    flush_i,
  input  nlej_pkg::tok_t          tok_i,
  output nlej_pkg::tok_t          tok_o,
  output logic                    hit_o
);

  logic [nlej_pkg::KEY_W-1:0] val_q;
  nlej_pkg::tok_t             tok_q;

  // stored value, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      val_q <= wr_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (flush_i) begin
      tok_q <= '0;
    end else if (shift_i) begin
      tok_q <= tok_i;
    end
  end

  assign tok_o = tok_q;
  assign hit_o = tok_q.valid && (tok_q.key == val_q);

endmodule

// ===== src/nlej_checker.sv =====
// Port-level checks for nested_loop_equi_join, bound to the top level.
// Depends on nlej_pkg.
module nlej_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [nlej_pkg::POS_W-1:0]        outer_position_o,
  input logic [nlej_pkg::POS_W-1:0]        inner_position_o,
  input logic                              matched_o,
  input logic                              last_o
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(outer_position_o)
      && $stable(inner_position_o) && $stable(matched_o) && $stable(last_o))
    else $error("result word changed while stalled");

  // a no-match word always closes its probe
  a_nomatch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !matched_o |-> last_o)
    else $error("no-match word without last");

  a_nomatch_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !matched_o |-> inner_position_o == '0)
    else $error("no-match word with nonzero inner position");

  // mid-probe words mean the block is still busy with that probe
  a_busy_midprobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("new item taken before probe finished");

endmodule

bind nested_loop_equi_join nlej_checker u_nlej_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .outer_position_o (outer_position_o),
  .inner_position_o (inner_position_o),
  .matched_o        (matched_o),
  .last_o           (last_o)
);

// ===== sim/tb_nested_loop_equi_join.sv =====
// Self-checking testbench for nested_loop_equi_join: directed and random join traffic,
// with predicted pairs checked word by word at the result port.
// Depends on src/nlej_pkg.sv, src/nested_loop_equi_join.sv and src/nlej_cell.sv.
`timescale 1ns / 1ps

module tb_nested_loop_equi_join;
  import nlej_pkg::*;

  localparam logic [1:0] MODE_NOP      = 2'd3;            // ignored by the block
  localparam int         SETTLE_CYCLES = INNER_DEPTH + 4; // worst probe walk plus margin
  localparam int         STALL_LIMIT   = 2000;            // cycles with no handshake at all
  localparam int         LONG_HOLD     = 400;             // one long result back-pressure

  typedef struct {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
  } join_item_t;

  typedef struct {
    logic [POS_W-1:0] outer_pos;
    logic [POS_W-1:0] inner_pos;
    logic             matched;
    logic             last;
  } join_pair_t;

  // DUT-facing signals, all known from time zero
  logic                 clk_i     = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic [1:0]           in_mode   = MODE_LOAD;
  logic [KEY_W-1:0]     in_key    = '0;
  logic                 out_stall = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_OUTER_BASE;
  logic [BASE_W-1:0]    cfg_data  = '0;

  logic                 in_stall;
  logic                 out_valid;
  logic [POS_W-1:0]     outer_position;
  logic [POS_W-1:0]     inner_position;
  logic                 matched;
  logic                 last;
  logic                 cfg_ready;

  // stimulus and expectation stores
  join_item_t           pending_items[$];
  join_pair_t           join_pairs_due[$];
  int                   queued_items = 0;
  logic [KEY_W-1:0]     key_pool[8];

  // shadow of the block state
  logic [KEY_W-1:0]     shadow_inner[INNER_DEPTH];
  int                   shadow_fill = 0;
  logic [ROWS_W-1:0]    shadow_rows = '0;
  logic [BASE_W-1:0]    shadow_outer_base = '0;
  logic [BASE_W-1:0]    shadow_inner_base = '0;

  // traffic shaping
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  logic                 long_hold_req = 1'b0;
  logic                 long_hold_done = 1'b0;
  int                   hold_left = 0;

  int                   mismatch_cnt = 0;
  int                   quiet_cycles = 0;

  nested_loop_equi_join u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .mode_i           (in_mode),
    .key_value_i      (in_key),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .outer_position_o (outer_position),
    .inner_position_o (inner_position),
    .matched_o        (matched),
    .last_o           (last),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Join predictor: applies one accepted word to the shadow state and queues
  // the pairs the block must emit for it, in inner row order.
  // ---------------------------------------------------------------------------
  function automatic void join_apply(input logic [1:0] mode, input logic [KEY_W-1:0] key);
    join_pair_t       pair;
    logic [POS_W-1:0] outer_pos;
    int               hits;
    int               seen;
    case (mode)
      MODE_LOAD: begin
        // full store drops the value, fill saturates
        if (shadow_fill < INNER_DEPTH) begin
          shadow_inner[shadow_fill] = key;
          shadow_fill++;
        end
      end
      MODE_CLEAR: begin
        // bases survive a clear
        shadow_fill = 0;
        shadow_rows = '0;
      end
      MODE_PROBE: begin
        outer_pos = {1'b0, shadow_rows} + {1'b0, shadow_outer_base};
        hits = 0;
        for (int i = 0; i < shadow_fill; i++)
          if (shadow_inner[i] == key) hits++;
        if (hits == 0) begin
          // no match (or empty store): single unmatched word, inner position zero
          pair.outer_pos = outer_pos;
          pair.inner_pos = '0;
          pair.matched   = 1'b0;
          pair.last      = 1'b1;
          join_pairs_due.push_back(pair);
        end else begin
          seen = 0;
          for (int i = 0; i < shadow_fill; i++) begin
            if (shadow_inner[i] == key) begin
              seen++;
              pair.outer_pos = outer_pos;
              pair.inner_pos = POS_W'(i) + {1'b0, shadow_inner_base};
              pair.matched   = 1'b1;
              pair.last      = (seen == hits);
              join_pairs_due.push_back(pair);
            end
          end
        end
        shadow_rows = shadow_rows + 1'b1; // wraps at 2^32
      end
      default: ; // unused mode: no effect
    endcase
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("mismatch: %s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Item driver. A word is taken at an edge with valid high and stall low;
  // it is predicted at that edge. A stalled word is held unchanged.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    join_item_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) join_apply(in_mode, in_key);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_mode  <= item.mode;
          in_key   <= item.key;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and stall generator. Checks each accepted word against the
  // oldest expected pair. One long hold-off is counted here when requested.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    join_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (join_pairs_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected word op=%0h ip=%0h m=%0b l=%0b",
                                outer_position, inner_position, matched, last));
      end else begin
        want = join_pairs_due.pop_front();
        if (outer_position !== want.outer_pos || inner_position !== want.inner_pos ||
            matched !== want.matched || last !== want.last) begin
          flag_mismatch($sformatf(
            "exp op=%0h ip=%0h m=%0b l=%0b, got op=%0h ip=%0h m=%0b l=%0b",
            want.outer_pos, want.inner_pos, want.matched, want.last,
            outer_position, inner_position, matched, last));
        end
      end
    end
    if (!rst_n) begin
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (long_hold_req && !long_hold_done) begin
      // sender keeps offering; the probe in flight backs up the input
      hold_left      <= LONG_HOLD;
      long_hold_done <= 1'b1;
      out_stall      <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog: any handshake on any channel resets the count
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_item(input logic [1:0] mode, input logic [KEY_W-1:0] key);
    join_item_t item;
    item.mode = mode;
    item.key  = key;
    pending_items.push_back(item);
    if (mode != MODE_NOP) queued_items++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BASE_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_OUTER_BASE) shadow_outer_base = val;
    else shadow_inner_base = val;
  endtask

  // wait until all words are in and all pairs are out, then let a trailing
  // load or ignored word finish before touching the registers
  task automatic settle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid || join_pairs_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] draw_key();
    if ($urandom_range(3) == 0) return $urandom();
    return key_pool[$urandom_range(7)];
  endfunction

  // one join sequence: usually a clear, a run of loads from a small key pool so
  // that probes hit often, then probes; now and then an ignored word as noise
  task automatic queue_join_batch(input bit fill_store);
    int n_load;
    int n_probe;
    foreach (key_pool[j]) begin
      case ($urandom_range(11))
        0:       key_pool[j] = 32'h0000_0000;
        1:       key_pool[j] = 32'hFFFF_FFFF;
        2:       key_pool[j] = 32'h8000_0000;
        3:       key_pool[j] = 32'h7FFF_FFFF;
        default: key_pool[j] = $urandom();
      endcase
    end
    n_load  = fill_store ? $urandom_range(62, 70) : $urandom_range(0, 12);
    n_probe = $urandom_range(1, 8);
    if ($urandom_range(3) != 0) add_item(MODE_CLEAR, $urandom());
    repeat (n_load) add_item(MODE_LOAD, draw_key());
    repeat (n_probe) add_item(MODE_PROBE, draw_key());
    if ($urandom_range(3) == 0) add_item(MODE_NOP, $urandom());
  endtask

  task automatic queue_until(input int target);
    while (queued_items < target) queue_join_batch($urandom_range(9) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;

    // directed part at the widest bases so both position sums carry into bit 32
    send_idle_pct <= 18;
    recv_idle_pct <= 77;
    write_reg(REG_OUTER_BASE, 32'hFFFF_FFFF);
    write_reg(REG_INNER_BASE, 32'hFFFF_FFFF);
    add_item(MODE_PROBE, 32'h0000_0000);   // empty store
    add_item(MODE_NOP,   32'hFFFF_FFFF);
    add_item(MODE_LOAD,  32'h8000_0000);
    add_item(MODE_LOAD,  32'h7FFF_FFFF);
    add_item(MODE_LOAD,  32'h0000_0000);
    add_item(MODE_LOAD,  32'hFFFF_FFFF);
    add_item(MODE_LOAD,  32'h0000_0000);
    add_item(MODE_LOAD,  32'h8000_0000);
    add_item(MODE_PROBE, 32'h0000_0000);   // two hits
    add_item(MODE_PROBE, 32'h8000_0000);   // first and last rows
    add_item(MODE_PROBE, 32'h7FFF_FFFF);
    add_item(MODE_PROBE, 32'hFFFF_FFFF);
    add_item(MODE_PROBE, 32'h0000_0001);   // no match
    add_item(MODE_NOP,   32'h0000_0000);
    add_item(MODE_PROBE, 32'h0000_0000);
    add_item(MODE_CLEAR, 32'h5A5A_5A5A);
    add_item(MODE_PROBE, 32'h0000_0000);   // row counter back at zero
    add_item(MODE_LOAD,  32'hAAAA_AAAA);
    add_item(MODE_LOAD,  32'h5555_5555);
    add_item(MODE_PROBE, 32'h5555_5555);
    add_item(MODE_PROBE, 32'hAAAA_AAAA);
    settle();

    // random, sender light and receiver heavy idling, zero bases
    write_reg(REG_OUTER_BASE, '0);
    write_reg(REG_INNER_BASE, '0);
    queue_until(120);
    settle();

    // random, idling swapped, random bases
    send_idle_pct <= 77;
    recv_idle_pct <= 18;
    write_reg(REG_OUTER_BASE, $urandom());
    write_reg(REG_INNER_BASE, $urandom());
    queue_until(220);
    settle();

    // random, no idling, one long result hold-off, a batch of 62 to 70 loads first
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    write_reg(REG_OUTER_BASE, $urandom());
    write_reg(REG_INNER_BASE, 32'hFFFF_FFFF);
    long_hold_req <= 1'b1;
    queue_join_batch(1'b1);
    queue_until(310);
    settle();

    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
